FILE: hw/rtl/mafs_pkg.sv
// ----------------------------------------------------------------------------
// mafs_pkg: shared types and tables for the MPEG audio frame synchronizer
// Header field tables, divider sizing and controller/datapath interface types.
// ----------------------------------------------------------------------------
package mafs_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 3456;

  localparam int unsigned DIVIDEND_W = 26;
  localparam int unsigned DIVISOR_W  = 17;
  localparam int unsigned DIV_CNT_W  = 5;
  localparam int unsigned FSIZE_W    = 29;

  localparam logic [31:0] SYNC_MASK = 32'hFFE0_0000;

  localparam logic [17:0] L1_SLOT_SCALE = 18'd12000;
  localparam logic [17:0] L23_SCALE     = 18'd144000;

  localparam logic ITEM_HEADER = 1'b0;
  localparam logic ITEM_BODY   = 1'b1;

  localparam logic [1:0] VER_MPEG1  = 2'd0;
  localparam logic [1:0] VER_MPEG2  = 2'd1;
  localparam logic [1:0] VER_MPEG25 = 2'd2;

  localparam logic [8:0] KBPS_TABLE [2][3][16] = '{
    '{ '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0},
       '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0},
       '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0} },
    '{ '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0},
       '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0},
       '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0} }
  };

  localparam logic [15:0] RATE_TABLE [9] = '{
    44100, 48000, 32000, 22050, 24000, 16000, 11025, 12000, 8000
  };

  typedef struct packed {
    logic accept;
    logic div_start;
    logic hdr_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_body;
    logic out_free;
    logic cand;
    logic div_done;
    logic size_ok;
  } dp_status_t;

endpackage

FILE: hw/rtl/mafs_div.sv
// ----------------------------------------------------------------------------
// mafs_div: bit-serial restoring divider
// One quotient bit per cycle for the frame-size calculation.
// ----------------------------------------------------------------------------
module mafs_div
  import mafs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic [DIVIDEND_W-1:0] quotient_o,
  output logic                  done_o
);

  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  dvs_q, dvs_d;
  logic [DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic [DIVISOR_W:0]    rem_sh;
  logic                  fits;

  assign rem_sh = {rem_q, quo_q[DIVIDEND_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    cnt_d = cnt_q;
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
      cnt_d = DIV_CNT_W'(DIVIDEND_W);
    end else if (cnt_q != '0) begin
      rem_d = fits ? DIVISOR_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[DIVISOR_W-1:0];
      quo_d = {quo_q[DIVIDEND_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o = quo_q;
  assign done_o     = (cnt_q == '0);

endmodule

FILE: hw/rtl/mafs_dp.sv
// ----------------------------------------------------------------------------
// mafs_dp: frame synchronizer datapath
// Header window, header decode, frame-size math, body count, output register.
// ----------------------------------------------------------------------------
module mafs_dp
  import mafs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctrl_cmd_t   cmd_i,
  output dp_status_t  status_o,
  input  logic [7:0]  in_byte_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic        out_kind_o,
  output logic        out_last_o,
  output logic [79:0] out_data_o
);

  logic [31:0] window_q, window_d;
  logic [2:0]  fill_q, fill_d;
  logic        in_body_q, in_body_d;
  logic [11:0] body_left_q, body_left_d;
  logic [11:0] left_dec;

  logic        out_valid_q;
  logic        out_kind_q;
  logic        out_last_q;
  logic [79:0] out_data_q;

  logic [31:0] shifted;
  logic [1:0]  lbits;
  logic [3:0]  bri;
  logic [1:0]  sr;
  logic        lsf, mpeg25, crc, pad, mono;
  logic [1:0]  layer;
  logic [3:0]  ridx;
  logic [8:0]  kbps;
  logic [5:0]  side;
  logic [1:0]  version;
  logic [17:0] scale;
  logic [DIVIDEND_W-1:0] dividend;
  logic [DIVISOR_W-1:0]  divisor;
  logic [DIVIDEND_W-1:0] quotient;
  logic                  div_done;
  logic [DIVIDEND_W:0]   slot_sum;
  logic [FSIZE_W-1:0]    fsize;
  logic                  out_free;
  logic                  body_acc;

  // candidate check on the window as it stands after this beat
  assign shifted = {window_q[23:0], in_byte_i};

  assign lbits  = window_q[18:17];
  assign bri    = window_q[15:12];
  assign sr     = window_q[11:10];
  assign mpeg25 = !window_q[20];
  assign lsf    = mpeg25 ? 1'b1 : !window_q[19];
  assign layer  = 2'd0 - lbits;
  assign ridx   = mpeg25 ? 4'd6 + {2'b00, sr} : {2'b00, sr} + (lsf ? 4'd3 : 4'd0);
  assign crc    = !window_q[16];
  assign pad    = window_q[9];
  assign mono   = (window_q[7:6] == 2'b11);
  assign kbps   = KBPS_TABLE[lsf][layer - 2'd1][bri];
  assign version = mpeg25 ? VER_MPEG25 : (lsf ? VER_MPEG2 : VER_MPEG1);

  always_comb begin
    side = '0;
    if (layer == 2'd3) begin
      if (lsf) begin
        side = mono ? 6'd9 : 6'd17;
      end else begin
        side = mono ? 6'd17 : 6'd32;
      end
      if (crc) begin
        side = side + 6'd2;
      end
    end
  end

  assign scale    = (layer == 2'd1) ? L1_SLOT_SCALE : L23_SCALE;
  assign dividend = {17'd0, kbps} * {8'd0, scale};
  assign divisor  = {1'b0, RATE_TABLE[ridx]} << ((layer == 2'd3) ? lsf : 1'b0);

  mafs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .quotient_o (quotient),
    .done_o     (div_done)
  );

  assign slot_sum = {1'b0, quotient} + (DIVIDEND_W+1)'(pad);
  assign fsize = (layer == 2'd1) ? FSIZE_W'({slot_sum, 2'b00}) - FSIZE_W'(4)
                                 : FSIZE_W'(slot_sum) - FSIZE_W'(4);

  assign out_free = !out_valid_q || out_ready_i;
  assign body_acc = cmd_i.accept && in_body_q;
  assign left_dec = body_left_q - 12'd1;

  assign status_o.in_body  = in_body_q;
  assign status_o.out_free = out_free;
  assign status_o.cand     = (fill_q >= 3'd3) &&
                             ((shifted & SYNC_MASK) == SYNC_MASK) &&
                             (shifted[18:17] != 2'b00) &&
                             (shifted[15:12] != 4'hF) && (shifted[15:12] != 4'h0) &&
                             (shifted[11:10] != 2'b11);
  assign status_o.div_done = div_done;
  assign status_o.size_ok  = (fsize != '0) && (fsize <= FSIZE_W'(MAX_FRAME_BYTES));

  always_comb begin
    window_d    = window_q;
    fill_d      = fill_q;
    in_body_d   = in_body_q;
    body_left_d = body_left_q;
    if (body_acc) begin
      body_left_d = left_dec;
      if (left_dec == '0) begin
        in_body_d = 1'b0;
        fill_d    = '0;
        window_d  = '0;
      end
    end else if (cmd_i.accept) begin
      window_d = shifted;
      if (fill_q < 3'd4) begin
        fill_d = fill_q + 3'd1;
      end
    end else if (cmd_i.hdr_load) begin
      in_body_d   = 1'b1;
      body_left_d = fsize[11:0];
      fill_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q    <= '0;
      fill_q      <= '0;
      in_body_q   <= 1'b0;
      body_left_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      window_q    <= window_d;
      fill_q      <= fill_d;
      in_body_q   <= in_body_d;
      body_left_q <= body_left_d;
      if (body_acc || cmd_i.hdr_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (body_acc) begin
      out_kind_q <= ITEM_BODY;
      out_last_q <= (left_dec == '0);
      out_data_q <= {72'd0, in_byte_i};
    end else if (cmd_i.hdr_load) begin
      out_kind_q <= ITEM_HEADER;
      out_last_q <= 1'b0;
      out_data_q <= {2'b00, side, fsize[11:0], (mono ? 2'd1 : 2'd2), crc, kbps,
                     ridx, version, layer, window_q, 8'd0};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_last_o  = out_last_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: hw/rtl/mafs_ctrl.sv
// ----------------------------------------------------------------------------
// mafs_ctrl: frame synchronizer controller
// Sequences byte intake, frame-size division and header result issue.
// ----------------------------------------------------------------------------
module mafs_ctrl
  import mafs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE) && (!status_i.in_body || status_i.out_free);

  always_comb begin
    state_d         = state_q;
    cmd_o.accept    = 1'b0;
    cmd_o.div_start = 1'b0;
    cmd_o.hdr_load  = 1'b0;
    case (state_q)
      S_IDLE: begin
        cmd_o.accept = in_valid_i && in_ready_o;
        if (cmd_o.accept && !status_i.in_body && status_i.cand) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        if (status_i.div_done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!status_i.size_ok) begin
          state_d = S_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.hdr_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hw/rtl/mpeg_audio_frame_sync.sv
// ----------------------------------------------------------------------------
// mpeg_audio_frame_sync: MPEG-1/2/2.5 audio frame header synchronizer
// Hunts for a valid frame header in a byte stream, reports it, then passes
// the frame body bytes with the last one flagged by tlast.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while hunting, and while passing a frame body
// when the output register is free; each body byte leaves as one beat. When the
// four-byte window looks like a header, the input stalls through a multiply
// state, the bit-serial frame-size divider (26 quotient bits) and a size check,
// longer while a header beat waits for the output register; a valid header then
// issues one header beat (tuser low). A rejected header resumes hunting one byte
// further on.
// ----------------------------------------------------------------------------
module mpeg_audio_frame_sync
  import mafs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] stream_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // [7:0] body_byte, [39:8] header_word,
                                      // [41:40] layer_number, [43:42] version_code,
                                      // [47:44] rate_index, [56:48] bitrate_kbps,
                                      // [57] crc_present, [59:58] channel_count,
                                      // [71:60] frame_bytes, [77:72] side_info_bytes
  output logic        m_axis_tuser,   // [0] item_kind
  output logic        m_axis_tlast    // last_of_frame
);

  ctrl_cmd_t  cmd;
  dp_status_t st;

  mafs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (st),
    .cmd_o      (cmd)
  );

  mafs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (st),
    .in_byte_i   (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_kind_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast),
    .out_data_o  (m_axis_tdata)
  );

`ifndef SYNTHESIS
  // a body byte taken always shows up as a beat on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && st.in_body) |=> m_axis_tvalid)
    else $error("body byte lost");

  // header beats never carry an empty frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[71:60] != '0))
    else $error("header with zero frame size");

  // no intake while the divider is running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !st.div_done |-> !s_axis_tready)
    else $error("input taken during division");
`endif

endmodule
